// File: src/assert_macros.svh
// assertion helpers, all sampled on clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge
`define HFVC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked in the cycle after a trigger
`define HFVC_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);

`endif

// File: src/hfvc_pkg.sv
package hfvc_pkg;

    // field widths
    localparam int COORD_WIDTH_DEF = 16;
    localparam int GAIN_W          = 16;
    localparam int LIMIT_W         = 15;
    localparam int HEAD_W          = 16;
    localparam int ERR_W           = 17;
    localparam int OUT_W           = 16;
    localparam int FRAC_BITS       = 8;
    localparam int QUOT_W          = LIMIT_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_KP_LIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KD_LIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KP_ANG      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KD_ANG      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIN_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_LIMIT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_RADIUS = 3'd6;

    // register reset values
    localparam logic [GAIN_W-1:0]  KP_LIN_RST      = 16'd41;
    localparam logic [GAIN_W-1:0]  KD_LIN_RST      = 16'd115;
    localparam logic [GAIN_W-1:0]  KP_ANG_RST      = 16'd64;
    localparam logic [GAIN_W-1:0]  KD_ANG_RST      = 16'd5;
    localparam logic [LIMIT_W-1:0] LIN_LIMIT_RST   = 15'd750;
    localparam logic [LIMIT_W-1:0] TURN_LIMIT_RST  = 15'd938;
    localparam logic [LIMIT_W-1:0] NEAR_RADIUS_RST = 15'd300;

    // heading arithmetic in centidegrees
    localparam logic [16:0]        HALF_TURN   = 17'd18000;
    localparam logic [16:0]        FULL_TURN   = 17'd36000;
    localparam logic [16:0]        TWO_TURNS   = 17'd72000;
    localparam logic signed [17:0] FULL_TURN_S = 18'sd36000;
    localparam logic signed [17:0] FOLD_LIMIT  = 18'sd30000;

endpackage

// File: src/hfvc_div.sv
module hfvc_div
    import hfvc_pkg::*;
#(
    parameter int DEN_W = COORD_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [DEN_W+QUOT_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    busy,
    output logic [QUOT_W-1:0]       quot
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic [QUOT_W-1:0] q_reg;
    logic [QUOT_W-1:0] q_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DEN_W:0]    trial;
    logic              fits;

    // one restoring step: shift in the next numerator bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, q_reg[QUOT_W-1]};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
        q_next   = {q_reg[QUOT_W-2:0], fits};
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(QUOT_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // remainder and quotient shift register; upper numerator bits are below den
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[DEN_W+QUOT_W-1:QUOT_W];
            q_reg   <= num[QUOT_W-1:0];
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign busy = cnt_reg != '0;
    assign quot = q_reg;

endmodule

// File: src/holonomic_follower_velocity_controller.sv
// channel  | handshake                 | payload
// ---------+---------------------------+--------------------------------------------
// input    | in_valid / in_stall       | goal_x, goal_y, goal_heading, robot_heading
// output   | out_valid / out_stall     | vel_x, vel_y, turn_rate, far_mode
// config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// the time from acceptance to result is set by the single shared multiplier stepping
// through the products and, in far mode, by the 15-step ratio divider; the next
// transaction is taken in the cycle after the result is registered.
// reset restores the gains and limits to their defaults and clears the stored errors;
// no clearing pass. a result waits in the output register under out_stall while the
// next transaction may already be taken.
`include "assert_macros.svh"

module holonomic_follower_velocity_controller
    import hfvc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] goal_x,
    input  logic signed [COORD_WIDTH-1:0] goal_y,
    input  logic [HEAD_W-1:0]             goal_heading,
    input  logic [HEAD_W-1:0]             robot_heading,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [OUT_W-1:0]       vel_x,
    output logic signed [OUT_W-1:0]       vel_y,
    output logic signed [OUT_W-1:0]       turn_rate,
    output logic                          far_mode,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    localparam int MW = (COORD_WIDTH + 1 > ERR_W + 1) ? COORD_WIDTH + 1 : ERR_W + 1;
    localparam int PW = 2 * MW;
    localparam int AW = PW + 1;

    typedef enum logic [15:0] {
        ST_IDLE     = 16'h0001,
        ST_WRAP     = 16'h0002,
        ST_FOLD     = 16'h0004,
        ST_PROD_P   = 16'h0008,
        ST_PROD_D   = 16'h0010,
        ST_ACC      = 16'h0020,
        ST_CLAMP    = 16'h0040,
        ST_SQ_X     = 16'h0080,
        ST_SQ_Y     = 16'h0100,
        ST_SQ_R     = 16'h0200,
        ST_CMP      = 16'h0400,
        ST_ORDER    = 16'h0800,
        ST_RMUL     = 16'h1000,
        ST_DIV_GO   = 16'h2000,
        ST_DIV_WAIT = 16'h4000,
        ST_FINISH   = 16'h8000
    } state_t;

    typedef enum logic [1:0] {
        CH_HEAD = 2'b00,
        CH_X    = 2'b01,
        CH_Y    = 2'b10
    } chan_t;

    state_t state_reg;
    state_t state_next;
    chan_t  chan_reg;

    // configuration registers
    logic [GAIN_W-1:0]  kp_lin_reg;
    logic [GAIN_W-1:0]  kd_lin_reg;
    logic [GAIN_W-1:0]  kp_ang_reg;
    logic [GAIN_W-1:0]  kd_ang_reg;
    logic [LIMIT_W-1:0] lin_limit_reg;
    logic [LIMIT_W-1:0] turn_limit_reg;
    logic [LIMIT_W-1:0] near_radius_reg;

    // captured transaction and working values
    logic signed [COORD_WIDTH-1:0] x_reg;
    logic signed [COORD_WIDTH-1:0] y_reg;
    logic [HEAD_W-1:0]             gh_in_reg;
    logic [HEAD_W-1:0]             rh_reg;
    logic [HEAD_W-1:0]             gh_reg;
    logic [HEAD_W-1:0]             gh_next;
    logic signed [ERR_W-1:0]       herr_reg;
    logic signed [ERR_W-1:0]       herr_next;
    logic signed [PW-1:0]          prod_reg;
    logic signed [PW-1:0]          prod_next;
    logic signed [AW-1:0]          acc_reg;
    logic                          far_reg;
    logic signed [OUT_W-1:0]       turn_res_reg;
    logic signed [OUT_W-1:0]       vx_res_reg;
    logic signed [OUT_W-1:0]       vy_res_reg;
    logic [COORD_WIDTH-1:0]        maj_reg;
    logic [COORD_WIDTH-1:0]        min_reg;
    logic                          xmaj_reg;

    // stored errors: heading of the previous tick, x and y of the last near-mode tick
    logic signed [ERR_W-1:0]       last_h_reg;
    logic signed [COORD_WIDTH-1:0] last_x_reg;
    logic signed [COORD_WIDTH-1:0] last_y_reg;

    // output register
    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] vel_x_reg;
    logic signed [OUT_W-1:0] vel_y_reg;
    logic signed [OUT_W-1:0] turn_rate_reg;
    logic                    far_mode_reg;

    // combinational helpers
    logic [16:0]             gh_sum;
    logic signed [17:0]      ediff;
    logic signed [MW-1:0]    e_sel;
    logic signed [MW-1:0]    prev_sel;
    logic signed [MW-1:0]    diff;
    logic [GAIN_W-1:0]       kp_sel;
    logic [GAIN_W-1:0]       kd_sel;
    logic [LIMIT_W-1:0]      lim_sel;
    logic signed [MW-1:0]    mul_a;
    logic signed [MW-1:0]    mul_b;
    logic signed [AW-1:0]    shifted;
    logic signed [AW-1:0]    lim_s;
    logic signed [OUT_W-1:0] pd_res;
    logic [COORD_WIDTH-1:0]  ax;
    logic [COORD_WIDTH-1:0]  ay;
    logic signed [OUT_W-1:0] lim_v;
    logic signed [OUT_W-1:0] q_v;
    logic signed [OUT_W-1:0] major_v;
    logic signed [OUT_W-1:0] minor_v;
    logic                    maj_neg;
    logic                    min_neg;
    logic signed [OUT_W-1:0] fin_vx;
    logic signed [OUT_W-1:0] fin_vy;
    logic                    in_accept;
    logic                    out_free;
    logic                    div_start;
    logic                    div_busy;
    logic [QUOT_W-1:0]       div_quot;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign div_start = state_reg == ST_DIV_GO;

    // configuration writes, taken at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_lin_reg      <= KP_LIN_RST;
            kd_lin_reg      <= KD_LIN_RST;
            kp_ang_reg      <= KP_ANG_RST;
            kd_ang_reg      <= KD_ANG_RST;
            lin_limit_reg   <= LIN_LIMIT_RST;
            turn_limit_reg  <= TURN_LIMIT_RST;
            near_radius_reg <= NEAR_RADIUS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_KP_LIN:      kp_lin_reg      <= cfg_data;
                REG_KD_LIN:      kd_lin_reg      <= cfg_data;
                REG_KP_ANG:      kp_ang_reg      <= cfg_data;
                REG_KD_ANG:      kd_ang_reg      <= cfg_data;
                REG_LIN_LIMIT:   lin_limit_reg   <= cfg_data[LIMIT_W-1:0];
                REG_TURN_LIMIT:  turn_limit_reg  <= cfg_data[LIMIT_W-1:0];
                REG_NEAR_RADIUS: near_radius_reg <= cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    // goal heading turned by half a turn and wrapped
    always_comb
    begin
        gh_sum = 17'(gh_in_reg) + HALF_TURN;
        if (gh_sum >= TWO_TURNS)
        begin
            gh_next = HEAD_W'(gh_sum - TWO_TURNS);
        end
        else if (gh_sum >= FULL_TURN)
        begin
            gh_next = HEAD_W'(gh_sum - FULL_TURN);
        end
        else
        begin
            gh_next = HEAD_W'(gh_sum);
        end
    end

    // heading error folded by a full turn when beyond +/-FOLD_LIMIT
    always_comb
    begin
        ediff = $signed({2'b00, gh_reg}) - $signed({2'b00, rh_reg});
        if (ediff > FOLD_LIMIT)
        begin
            herr_next = ERR_W'(ediff - FULL_TURN_S);
        end
        else if (ediff < -FOLD_LIMIT)
        begin
            herr_next = ERR_W'(ediff + FULL_TURN_S);
        end
        else
        begin
            herr_next = ERR_W'(ediff);
        end
    end

    // operands of the pd channel in work
    always_comb
    begin
        e_sel    = '0;
        prev_sel = '0;
        kp_sel   = kp_lin_reg;
        kd_sel   = kd_lin_reg;
        lim_sel  = lin_limit_reg;
        unique case (chan_reg)
            CH_HEAD:
            begin
                e_sel    = MW'(herr_reg);
                prev_sel = MW'(last_h_reg);
                kp_sel   = kp_ang_reg;
                kd_sel   = kd_ang_reg;
                lim_sel  = turn_limit_reg;
            end
            CH_X:
            begin
                e_sel    = MW'(x_reg);
                prev_sel = MW'(last_x_reg);
            end
            CH_Y:
            begin
                e_sel    = MW'(y_reg);
                prev_sel = MW'(last_y_reg);
            end
            default: ;
        endcase
        diff = e_sel - prev_sel;
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_PROD_P:
            begin
                mul_a = MW'(kp_sel);
                mul_b = e_sel;
            end
            ST_PROD_D:
            begin
                mul_a = MW'(kd_sel);
                mul_b = diff;
            end
            ST_SQ_X:
            begin
                mul_a = MW'(x_reg);
                mul_b = MW'(x_reg);
            end
            ST_SQ_Y:
            begin
                mul_a = MW'(y_reg);
                mul_b = MW'(y_reg);
            end
            ST_SQ_R:
            begin
                mul_a = MW'(near_radius_reg);
                mul_b = MW'(near_radius_reg);
            end
            ST_RMUL:
            begin
                mul_a = MW'(lin_limit_reg);
                mul_b = MW'(min_reg);
            end
            default: ;
        endcase
        prod_next = mul_a * mul_b;
    end

    // q8.8 floor and symmetric clamp
    always_comb
    begin
        shifted = acc_reg >>> FRAC_BITS;
        lim_s   = AW'(lim_sel);
        if (shifted > lim_s)
        begin
            pd_res = OUT_W'(lim_s);
        end
        else if (shifted < -lim_s)
        begin
            pd_res = OUT_W'(-lim_s);
        end
        else
        begin
            pd_res = OUT_W'(shifted);
        end
    end

    // axis magnitudes for far mode
    always_comb
    begin
        ax = x_reg[COORD_WIDTH-1] ? (COORD_WIDTH'(0) - $unsigned(x_reg)) : $unsigned(x_reg);
        ay = y_reg[COORD_WIDTH-1] ? (COORD_WIDTH'(0) - $unsigned(y_reg)) : $unsigned(y_reg);
    end

    // final velocities: near-mode pd results, or far mode velocities from the ratio quotient
    always_comb
    begin
        lim_v   = OUT_W'(lin_limit_reg);
        q_v     = OUT_W'(div_quot);
        maj_neg = xmaj_reg ? x_reg[COORD_WIDTH-1] : y_reg[COORD_WIDTH-1];
        min_neg = xmaj_reg ? y_reg[COORD_WIDTH-1] : x_reg[COORD_WIDTH-1];
        major_v = maj_neg ? -lim_v : lim_v;
        minor_v = min_neg ? -q_v : q_v;
        if (!far_reg)
        begin
            fin_vx = vx_res_reg;
            fin_vy = vy_res_reg;
        end
        else if (xmaj_reg)
        begin
            fin_vx = major_v;
            fin_vy = minor_v;
        end
        else
        begin
            fin_vx = minor_v;
            fin_vy = major_v;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_WRAP;
            ST_WRAP:     state_next = ST_FOLD;
            ST_FOLD:     state_next = ST_PROD_P;
            ST_PROD_P:   state_next = ST_PROD_D;
            ST_PROD_D:   state_next = ST_ACC;
            ST_ACC:      state_next = ST_CLAMP;
            ST_CLAMP:
            begin
                priority if (chan_reg == CH_HEAD) state_next = ST_SQ_X;
                else if (chan_reg == CH_X)        state_next = ST_PROD_P;
                else                              state_next = ST_FINISH;
            end
            ST_SQ_X:     state_next = ST_SQ_Y;
            ST_SQ_Y:     state_next = ST_SQ_R;
            ST_SQ_R:     state_next = ST_CMP;
            ST_CMP:      state_next = (acc_reg > AW'(prod_reg)) ? ST_ORDER : ST_PROD_P;
            ST_ORDER:    state_next = ST_RMUL;
            ST_RMUL:     state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: if (!div_busy) state_next = ST_FINISH;
            ST_FINISH:   if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chan_reg      <= CH_HEAD;
            out_valid_reg <= 1'b0;
            last_h_reg    <= '0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE)
            begin
                chan_reg <= CH_HEAD;
            end
            else if (state_reg == ST_CMP)
            begin
                chan_reg <= CH_X;
            end
            else if (state_reg == ST_CLAMP && chan_reg == CH_X)
            begin
                chan_reg <= CH_Y;
            end

            // stored errors
            if (state_reg == ST_CLAMP && chan_reg == CH_HEAD)
            begin
                last_h_reg <= herr_reg;
            end
            if (state_reg == ST_CLAMP && chan_reg == CH_Y)
            begin
                last_x_reg <= x_reg;
                last_y_reg <= y_reg;
            end

            // output register valid
            if (state_reg == ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (in_accept)
        begin
            x_reg     <= goal_x;
            y_reg     <= goal_y;
            gh_in_reg <= goal_heading;
            rh_reg    <= robot_heading;
        end
        if (state_reg == ST_WRAP)
        begin
            gh_reg <= gh_next;
        end
        if (state_reg == ST_FOLD)
        begin
            herr_reg <= herr_next;
        end
        if (state_reg == ST_PROD_D || state_reg == ST_SQ_Y)
        begin
            acc_reg <= AW'(prod_reg);
        end
        if (state_reg == ST_ACC || state_reg == ST_SQ_R)
        begin
            acc_reg <= acc_reg + AW'(prod_reg);
        end
        if (state_reg == ST_CMP)
        begin
            far_reg <= acc_reg > AW'(prod_reg);
        end
        if (state_reg == ST_CLAMP)
        begin
            unique case (chan_reg)
                CH_HEAD: turn_res_reg <= pd_res;
                CH_X:    vx_res_reg   <= pd_res;
                CH_Y:    vy_res_reg   <= pd_res;
                default: ;
            endcase
        end
        if (state_reg == ST_ORDER)
        begin
            xmaj_reg <= ax >= ay;
            maj_reg  <= (ax >= ay) ? ax : ay;
            min_reg  <= (ax >= ay) ? ay : ax;
        end
        if (state_reg == ST_FINISH && out_free)
        begin
            vel_x_reg     <= fin_vx;
            vel_y_reg     <= fin_vy;
            turn_rate_reg <= turn_res_reg;
            far_mode_reg  <= far_reg;
        end
    end

    // ratio divider: lin_limit * minor / major
    hfvc_div #(
        .DEN_W (COORD_WIDTH)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_reg[COORD_WIDTH+QUOT_W-1:0]),
        .den   (maj_reg),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;
    assign vel_x     = vel_x_reg;
    assign vel_y     = vel_y_reg;
    assign turn_rate = turn_rate_reg;
    assign far_mode  = far_mode_reg;

    // checks
    `HFVC_ASSERT(a_turn_in_limit, !out_valid || ($signed(turn_rate) <= $signed({1'b0, turn_limit_reg}) && $signed(turn_rate) >= -$signed({1'b0, turn_limit_reg})), "turn rate beyond limit")
    `HFVC_ASSERT(a_vel_x_in_limit, !out_valid || ($signed(vel_x) <= $signed({1'b0, lin_limit_reg}) && $signed(vel_x) >= -$signed({1'b0, lin_limit_reg})), "x velocity beyond limit")
    `HFVC_ASSERT_NEXT(a_busy_after_accept, in_accept, in_stall, "transaction taken while not busy")
    `HFVC_ASSERT(a_div_idle, state_reg != ST_IDLE || !div_busy, "divider running while idle")

endmodule

// File: sim/hfvc_command_checker.sv
module hfvc_command_checker
    import hfvc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] goal_x,
    input  logic signed [COORD_WIDTH-1:0] goal_y,
    input  logic [HEAD_W-1:0]             goal_heading,
    input  logic [HEAD_W-1:0]             robot_heading,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic signed [OUT_W-1:0]       vel_x,
    input  logic signed [OUT_W-1:0]       vel_y,
    input  logic signed [OUT_W-1:0]       turn_rate,
    input  logic                          far_mode,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    output int                            fail_count,
    output int                            pending
);

    typedef struct packed {
        logic [OUT_W-1:0] vx;
        logic [OUT_W-1:0] vy;
        logic [OUT_W-1:0] turn;
        logic             far;
    } command_t;

    // shadow copies of the gain and limit registers
    logic [GAIN_W-1:0]  kp_lin;
    logic [GAIN_W-1:0]  kd_lin;
    logic [GAIN_W-1:0]  kp_ang;
    logic [GAIN_W-1:0]  kd_ang;
    logic [LIMIT_W-1:0] lin_limit;
    logic [LIMIT_W-1:0] turn_limit;
    logic [LIMIT_W-1:0] near_radius;

    // error history for the derivative terms
    longint prev_heading_err;
    longint prev_x_err;
    longint prev_y_err;

    command_t expected_cmds[$];
    int       mismatches;

    function automatic longint sign_of(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic longint abs_of(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // q8.8 pd sum, floored by the arithmetic shift, then clamped both ways
    function automatic longint pd_clamped(longint kp, longint kd, longint err, longint prev,
                                          longint lim);
        longint q;
        q = (kp * err + kd * (err - prev)) >>> FRAC_BITS;
        if (q > lim)
            q = lim;
        else if (q < -lim)
            q = -lim;
        return q;
    endfunction

    // one control tick: turn rate always, then ratio mode or pd position mode
    function automatic command_t next_command(longint x, longint y, longint gh_raw, longint rh);
        longint   head_err;
        longint   vx;
        longint   vy;
        longint   turn;
        longint   lim;
        longint   ax;
        longint   ay;
        command_t cmd;
        head_err = (gh_raw + longint'(HALF_TURN)) % longint'(FULL_TURN) - rh;
        // fold an error beyond FOLD_LIMIT by a full turn toward zero
        if (abs_of(head_err) > longint'(FOLD_LIMIT))
            head_err = -sign_of(head_err) * (longint'(FULL_TURN) - abs_of(head_err));
        turn = pd_clamped(longint'(kp_ang), longint'(kd_ang), head_err, prev_heading_err,
                          longint'(turn_limit));
        prev_heading_err = head_err;
        cmd.far = (x * x + y * y) > (longint'(near_radius) * longint'(near_radius));
        if (cmd.far)
        begin
            // major axis at the limit, minor axis scaled by the ratio
            lim = longint'(lin_limit);
            ax = abs_of(x);
            ay = abs_of(y);
            if (ax >= ay)
            begin
                vx = lim * sign_of(x);
                vy = (ax != 0) ? (lim * ay / ax) * sign_of(y) : 0;
            end
            else
            begin
                vy = lim * sign_of(y);
                vx = (lim * ax / ay) * sign_of(x);
            end
        end
        else
        begin
            vx = pd_clamped(longint'(kp_lin), longint'(kd_lin), x, prev_x_err,
                            longint'(lin_limit));
            vy = pd_clamped(longint'(kp_lin), longint'(kd_lin), y, prev_y_err,
                            longint'(lin_limit));
            prev_x_err = x;
            prev_y_err = y;
        end
        cmd.vx = vx[OUT_W-1:0];
        cmd.vy = vy[OUT_W-1:0];
        cmd.turn = turn[OUT_W-1:0];
        return cmd;
    endfunction

    task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name,
                     $signed(want), $signed(got));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        command_t want;
        if (!rst_n)
        begin
            kp_lin = KP_LIN_RST;
            kd_lin = KD_LIN_RST;
            kp_ang = KP_ANG_RST;
            kd_ang = KD_ANG_RST;
            lin_limit = LIN_LIMIT_RST;
            turn_limit = TURN_LIMIT_RST;
            near_radius = NEAR_RADIUS_RST;
            prev_heading_err = 0;
            prev_x_err = 0;
            prev_y_err = 0;
            expected_cmds.delete();
            mismatches = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            // register write transaction
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_KP_LIN:      kp_lin = cfg_data[GAIN_W-1:0];
                    REG_KD_LIN:      kd_lin = cfg_data[GAIN_W-1:0];
                    REG_KP_ANG:      kp_ang = cfg_data[GAIN_W-1:0];
                    REG_KD_ANG:      kd_ang = cfg_data[GAIN_W-1:0];
                    REG_LIN_LIMIT:   lin_limit = cfg_data[LIMIT_W-1:0];
                    REG_TURN_LIMIT:  turn_limit = cfg_data[LIMIT_W-1:0];
                    REG_NEAR_RADIUS: near_radius = cfg_data[LIMIT_W-1:0];
                    default:         ;
                endcase
            end
            // result transaction against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (expected_cmds.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected result: expected none, actual %0d %0d %0d %0d",
                             $time, vel_x, vel_y, turn_rate, far_mode);
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    check_field("vel_x", want.vx, vel_x);
                    check_field("vel_y", want.vy, vel_y);
                    check_field("turn_rate", want.turn, turn_rate);
                    check_field("far_mode", {{(OUT_W-1){1'b0}}, want.far},
                                {{(OUT_W-1){1'b0}}, far_mode});
                end
            end
            // input transaction
            if (in_valid && !in_stall)
                expected_cmds.push_back(next_command(longint'(goal_x), longint'(goal_y),
                                                     longint'(goal_heading),
                                                     longint'(robot_heading)));
            fail_count <= mismatches;
            pending <= expected_cmds.size();
        end
    end

endmodule

// File: sim/holonomic_follower_velocity_controller_test.sv
module holonomic_follower_velocity_controller_test;
    import hfvc_pkg::*;

    localparam int COORD_W         = COORD_WIDTH_DEF;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int ITEMS_PER_PHASE = 160;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum int { FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_TOGGLE } flow_mode_e;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [COORD_W-1:0] goal_x;
    logic signed [COORD_W-1:0] goal_y;
    logic [HEAD_W-1:0]         goal_heading;
    logic [HEAD_W-1:0]         robot_heading;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [OUT_W-1:0]   vel_x;
    logic signed [OUT_W-1:0]   vel_y;
    logic signed [OUT_W-1:0]   turn_rate;
    logic                      far_mode;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    int fail_count;
    int pending;
    int holds_wanted;
    int holds_served = 0;
    int idle_cycles = 0;
    int radius_now;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    holonomic_follower_velocity_controller #(
        .COORD_WIDTH(COORD_W)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .goal_x(goal_x),
        .goal_y(goal_y),
        .goal_heading(goal_heading),
        .robot_heading(robot_heading),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .vel_x(vel_x),
        .vel_y(vel_y),
        .turn_rate(turn_rate),
        .far_mode(far_mode),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    hfvc_command_checker #(
        .COORD_WIDTH(COORD_W)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .goal_x(goal_x),
        .goal_y(goal_y),
        .goal_heading(goal_heading),
        .robot_heading(robot_heading),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .vel_x(vel_x),
        .vel_y(vel_y),
        .turn_rate(turn_rate),
        .far_mode(far_mode),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .fail_count(fail_count),
        .pending(pending)
    );

    // watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result side: stall segments of random flavor plus requested long hold-offs
    initial
    begin : receiver
        flow_mode_e mode;
        int         seg_len;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (holds_served < holds_wanted)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                holds_served++;
            end
            else
            begin
                mode = flow_mode_e'($urandom_range(0, 3));
                seg_len = $urandom_range(8, 64);
                repeat (seg_len)
                begin
                    case (mode)
                        FLOW_FREE:  out_stall <= 1'b0;
                        FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                        FLOW_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                        default:    out_stall <= ~out_stall;
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // offer one transaction and return right after the edge that takes it
    task automatic send_cmd(input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
                            input logic [HEAD_W-1:0] gh, input logic [HEAD_W-1:0] rh);
        in_valid <= 1'b1;
        goal_x <= x;
        goal_y <= y;
        goal_heading <= gh;
        robot_heading <= rh;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
    endtask

    // stop offering and wait until every predicted result has come out
    task automatic drain(input int tail);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (tail) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // full register set, written only once the block has gone quiet
    task automatic apply_setting(input logic [CFG_DATA_W-1:0] kp_l, input logic [CFG_DATA_W-1:0] kd_l,
                                 input logic [CFG_DATA_W-1:0] kp_a, input logic [CFG_DATA_W-1:0] kd_a,
                                 input logic [CFG_DATA_W-1:0] lin, input logic [CFG_DATA_W-1:0] turn,
                                 input logic [CFG_DATA_W-1:0] near);
        drain(8);
        write_reg(REG_KP_LIN, kp_l);
        write_reg(REG_KD_LIN, kd_l);
        write_reg(REG_KP_ANG, kp_a);
        write_reg(REG_KD_ANG, kd_a);
        write_reg(REG_LIN_LIMIT, lin);
        write_reg(REG_TURN_LIMIT, turn);
        write_reg(REG_NEAR_RADIUS, near);
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 65535)));
        radius_now = int'(near[LIMIT_W-1:0]);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        if ($urandom_range(0, 3) == 0)
            return CFG_DATA_W'($urandom_range(0, 65535));
        return CFG_DATA_W'($urandom_range(0, 1023));
    endfunction

    // bursts of goals, mostly around the near circle, some raw noise
    task automatic send_random_run(input int count);
        int          left;
        int          burst;
        int          pick;
        int          span;
        int          xi;
        int          yi;
        int          tmp;
        logic [31:0] rnd;
        logic [31:0] rnd_head;
        logic [15:0] gh;
        logic [15:0] rh;
        left = count;
        span = radius_now * 3 / 2 + 8;
        if (span > 32767)
            span = 32767;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && left > 0)
            begin
                pick = $urandom_range(0, 19);
                rnd = $urandom;
                rnd_head = $urandom;
                if (pick < 12)
                begin
                    xi = int'($urandom_range(0, 2 * span)) - span;
                    yi = int'($urandom_range(0, 2 * span)) - span;
                end
                else if (pick < 16)
                begin
                    xi = int'($signed(rnd[15:0]));
                    yi = int'($signed(rnd[31:16]));
                end
                else if (pick < 18)
                begin
                    // right on the near circle along an axis
                    xi = radius_now + int'($urandom_range(0, 2)) - 1;
                    yi = int'($urandom_range(0, 2)) - 1;
                end
                else
                begin
                    // zero axis or equal magnitudes
                    xi = int'($urandom_range(0, span));
                    yi = rnd[2] ? xi : 0;
                end
                if (pick >= 16)
                begin
                    if (rnd[0])
                        xi = -xi;
                    if (rnd[1])
                        yi = -yi;
                    if (rnd[3])
                    begin
                        tmp = xi;
                        xi = yi;
                        yi = tmp;
                    end
                end
                gh = ($urandom_range(0, 9) == 0) ? rnd_head[15:0]
                                                 : 16'($urandom_range(0, 35999));
                rh = ($urandom_range(0, 9) == 0) ? rnd_head[31:16]
                                                 : 16'($urandom_range(0, 35999));
                send_cmd(xi[15:0], yi[15:0], gh, rh);
                burst--;
                left--;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        goal_x <= '0;
        goal_y <= '0;
        goal_heading <= '0;
        robot_heading <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        holds_wanted <= 0;
        radius_now = int'(NEAR_RADIUS_RST);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed goals under the reset gains
        send_cmd(0, 0, 18000, 0);                  // zero heading error, at the goal
        send_cmd(100, -50, 0, 0);                  // turn rate clamps
        send_cmd(120, -40, 12000, 0);              // error right at the fold limit
        send_cmd(-200, 150, 14000, 0);             // positive error folded
        send_cmd(300, 0, 18000, 30001);            // negative error folded, on the circle
        send_cmd(301, 0, 100, 200);                // far, minor axis zero
        send_cmd(0, -5000, 65535, 0);              // far, y major, goal heading out of range
        send_cmd(-500, 500, 0, 65535);             // equal magnitudes, robot heading out of range
        send_cmd(32767, 32767, 35999, 35999);
        send_cmd(-32768, -32768, 0, 35999);
        send_cmd(-32768, 0, 65535, 65535);
        send_cmd(1000, -333, 9000, 27000);
        send_cmd(50, 60, 20000, 1000);             // near after far keeps the old errors
        send_cmd(-299, 0, 5000, 34000);
        send_cmd(0, 299, 30000, 100);
        send_cmd(212, -212, 17999, 18000);
        send_cmd(213, 212, 0, 18000);
        send_cmd(-7, 32767, 20000, 100);
        holds_wanted <= holds_wanted + 1;
        send_random_run(150);

        // every register at its top, limits written with the spare bit set
        apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_random_run(150);

        // everything zero: only the origin is near
        apply_setting(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(0, 0, 0, 0);
        send_cmd(1, 0, 35999, 0);
        send_random_run(150);

        for (int phase = 0; phase < 6; phase++)
        begin
            apply_setting(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                          CFG_DATA_W'($urandom_range(0, 65535)),
                          CFG_DATA_W'($urandom_range(0, 65535)),
                          ($urandom_range(0, 2) == 0) ? CFG_DATA_W'($urandom_range(0, 65535))
                                                      : CFG_DATA_W'($urandom_range(1, 2000)));
            if (phase == 2)
                holds_wanted <= holds_wanted + 1;
            send_random_run(ITEMS_PER_PHASE);
        end

        drain(60);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/hfvc_pkg.sv
src/hfvc_div.sv
src/holonomic_follower_velocity_controller.sv
sim/hfvc_command_checker.sv
sim/holonomic_follower_velocity_controller_test.sv
